### rtl/fxalu_pkg.sv
// fxalu_pkg: shared types, opcodes, status codes and the saturating finish
// function for the q24.8 fixed-point alu; no dependencies
`timescale 1ns / 1ps

package fxalu_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int WIDE_BITS     = 2 * WORD_BITS + 1;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_mag;
    typedef logic        [WIDE_BITS-1:0] t_wide;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV,
        KIND_GT, KIND_LT, KIND_GE, KIND_LE, KIND_EQ, KIND_NE,
        KIND_INC, KIND_DEC, KIND_MIN, KIND_MAX, KIND_TO_INT, KIND_FROM_INT
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        UNIT_ALU,
        UNIT_MUL,
        UNIT_DIV
    } t_unit;

    // decoded item as it travels from the front end to the execution side
    typedef struct packed {
        t_kind kind;
        t_unit unit;
        t_word a;
        t_word b;
        t_mag  mag_a;
        t_mag  mag_b;
        logic  neg;
    } t_op;

    typedef struct packed {
        t_word res;
        logic  ovf;
    } t_fin;

    // apply the sign to a wide magnitude, clamping to the word range
    function automatic t_fin finish_mag(input logic neg, input t_wide mag);
        t_wide limit;
        t_mag  m;
        t_fin  f;
        limit = t_wide'(WORD_MAX) + t_wide'(neg);
        f.ovf = mag > limit;
        m     = f.ovf ? limit[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        f.res = neg ? t_word'(-m) : t_word'(m);
        return f;
    endfunction

endpackage

### rtl/fxalu_front.sv
// fxalu_front: accepts items, classifies them by execution unit and
// precomputes operand magnitudes and result sign; uses fxalu_pkg
`timescale 1ns / 1ps

module fxalu_front import fxalu_pkg::*; (
    input  logic       i_start,
    input  logic [3:0] i_kind,
    input  t_word      i_operand_a,
    input  t_word      i_operand_b,
    input  logic       i_full,
    output logic       o_busy,
    output logic       o_push,
    output t_op        o_op
);

    always_comb begin
        o_busy = i_full;
        o_push = i_start & ~i_full;

        o_op.kind  = t_kind'(i_kind);
        o_op.a     = i_operand_a;
        o_op.b     = i_operand_b;
        o_op.mag_a = i_operand_a[WORD_BITS-1] ? t_mag'(-i_operand_a) : t_mag'(i_operand_a);
        o_op.mag_b = i_operand_b[WORD_BITS-1] ? t_mag'(-i_operand_b) : t_mag'(i_operand_b);
        o_op.neg   = i_operand_a[WORD_BITS-1] ^ i_operand_b[WORD_BITS-1];

        case (t_kind'(i_kind))
            KIND_MUL: begin
                o_op.unit = UNIT_MUL;
            end
            KIND_DIV: begin
                o_op.unit = UNIT_DIV;
            end
            default: begin
                o_op.unit = UNIT_ALU;
            end
        endcase
    end

endmodule

### rtl/fxalu_queue.sv
// fxalu_queue: short fifo of decoded items between front end and execution
// side; the head is taken whenever present; uses fxalu_pkg
`timescale 1ns / 1ps

module fxalu_queue import fxalu_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    t_op              r_head;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    always_comb begin
        pop      = r_count != '0;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
        // head follows the next read slot; an item written into that slot
        // now is taken straight from the input
        if (i_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_op;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = pop;
    assign o_head  = r_head;

endmodule

### rtl/fxalu_div.sv
// fxalu_div: pipelined restoring divider, one quotient bit per stage, then
// round half away from zero and saturate; uses fxalu_pkg
`timescale 1ns / 1ps

module fxalu_div import fxalu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  t_mag    i_num_mag,
    input  t_mag    i_den_mag,
    input  logic    i_neg,
    input  logic    i_sign_a,
    output t_word   o_res,
    output t_status o_status
);

    localparam int QW = WORD_BITS + FRAC_BITS;

    logic [QW-1:0]        r_num  [QW+1];
    logic [QW-1:0]        r_quo  [QW+1];
    t_mag                 r_rem  [QW+1];
    t_mag                 r_den  [QW+1];
    logic                 r_neg  [QW+1];
    logic                 r_sgn  [QW+1];
    logic [QW:0]          r_qr;
    logic                 r_qr_neg;
    logic                 r_qr_dz;
    logic                 r_qr_sgn;
    logic                 rnd_up;
    t_fin                 fin;

    always_ff @(posedge i_clk) begin
        r_num[0] <= {i_num_mag, {FRAC_BITS{1'b0}}};
        r_quo[0] <= '0;
        r_rem[0] <= '0;
        r_den[0] <= i_den_mag;
        r_neg[0] <= i_neg;
        r_sgn[0] <= i_sign_a;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [WORD_BITS:0] trial;
        logic [WORD_BITS:0] diff;
        logic               ge;

        assign trial = {r_rem[k], r_num[k][QW-1]};
        assign diff  = trial - {1'b0, r_den[k]};
        assign ge    = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            r_num[k+1] <= r_num[k] << 1;
            r_quo[k+1] <= {r_quo[k][QW-2:0], ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_sgn[k+1] <= r_sgn[k];
        end
    end

    // round up when twice the remainder reaches the divisor
    assign rnd_up = {r_rem[QW], 1'b0} >= {1'b0, r_den[QW]};

    always_ff @(posedge i_clk) begin
        r_qr     <= {1'b0, r_quo[QW]} + (QW+1)'(rnd_up);
        r_qr_neg <= r_neg[QW];
        r_qr_dz  <= r_den[QW] == '0;
        r_qr_sgn <= r_sgn[QW];
    end

    assign fin = finish_mag(r_qr_neg, t_wide'(r_qr));

    always_ff @(posedge i_clk) begin
        if (r_qr_dz) begin
            o_res    <= r_qr_sgn ? WORD_MIN : WORD_MAX;
            o_status <= ST_DIV0;
        end else begin
            o_res    <= fin.res;
            o_status <= fin.ovf ? ST_OVF : ST_OK;
        end
    end

endmodule

### rtl/fxalu_back.sv
// fxalu_back: execution side; simple ops and multiply finish in two stages
// and wait in a delay line aligned to the divider; uses fxalu_pkg, fxalu_div
`timescale 1ns / 1ps

module fxalu_back import fxalu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_op        i_op,
    output logic       o_strobe,
    output t_word      o_result,
    output logic       o_flag,
    output logic [1:0] o_status
);

    // divider: input stage, one stage per quotient bit, round, saturate
    localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 3;
    localparam int DLY     = DIV_LAT - 2;
    localparam int PROD_W  = 2 * WORD_BITS;
    localparam t_wide MUL_HALF = t_wide'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        t_word   res;
        logic    flag;
        t_status status;
        logic    is_div;
    } t_res;

    typedef logic [PROD_W-1:0] t_prod;

    t_res           n1, r1, n2, r2, n_out, r_out;
    t_res           r_dly [DLY];
    logic [DLY-1:0] r_dly_vld;
    logic           r1_valid, r2_valid, r_strobe;
    logic           r1_is_mul, r1_neg;
    t_prod          r1_prod;
    t_word          div_res;
    t_status        div_status;

    t_word          opb, sum, sat;
    logic           do_sub, same, ovf, a_lt, a_gt, a_eq;
    logic [FRAC_BITS:0] top;
    t_wide          mul_round;
    t_fin           mul_fin;

    fxalu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_num_mag (i_op.mag_a),
        .i_den_mag (i_op.mag_b),
        .i_neg     (i_op.neg),
        .i_sign_a  (i_op.a[WORD_BITS-1]),
        .o_res     (div_res),
        .o_status  (div_status)
    );

    // first stage: simple ops
    always_comb begin
        do_sub = (i_op.kind == KIND_SUB) || (i_op.kind == KIND_DEC);
        opb    = ((i_op.kind == KIND_INC) || (i_op.kind == KIND_DEC)) ? t_word'(1) : i_op.b;
        sum    = do_sub ? i_op.a - opb : i_op.a + opb;
        same   = i_op.a[WORD_BITS-1] == opb[WORD_BITS-1];
        ovf    = (do_sub ? !same : same) && (sum[WORD_BITS-1] != i_op.a[WORD_BITS-1]);
        sat    = i_op.a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
        a_lt   = $signed(i_op.a) < $signed(i_op.b);
        a_gt   = $signed(i_op.a) > $signed(i_op.b);
        a_eq   = i_op.a == i_op.b;
        top    = i_op.a[WORD_BITS-1 -: FRAC_BITS+1];

        n1.res    = '0;
        n1.flag   = 1'b0;
        n1.status = ST_OK;
        n1.is_div = i_op.unit == UNIT_DIV;

        case (i_op.kind)
            KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
                n1.res    = ovf ? sat : sum;
                n1.status = ovf ? ST_OVF : ST_OK;
            end
            KIND_GT: begin
                n1.flag = a_gt;
            end
            KIND_LT: begin
                n1.flag = a_lt;
            end
            KIND_GE: begin
                n1.flag = !a_lt;
            end
            KIND_LE: begin
                n1.flag = !a_gt;
            end
            KIND_EQ: begin
                n1.flag = a_eq;
            end
            KIND_NE: begin
                n1.flag = !a_eq;
            end
            KIND_MIN: begin
                n1.res = a_lt ? i_op.a : i_op.b;
            end
            KIND_MAX: begin
                n1.res = a_gt ? i_op.a : i_op.b;
            end
            KIND_TO_INT: begin
                n1.res = i_op.a >>> FRAC_BITS;
            end
            KIND_FROM_INT: begin
                // bits shifted out must all match the sign
                if ((&top) || !(|top)) begin
                    n1.res = i_op.a << FRAC_BITS;
                end else begin
                    n1.res    = sat;
                    n1.status = ST_OVF;
                end
            end
            default: begin
                n1.res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r1        <= n1;
        r1_is_mul <= i_op.unit == UNIT_MUL;
        r1_neg    <= i_op.neg;
        r1_prod   <= t_prod'(i_op.mag_a) * t_prod'(i_op.mag_b);
    end

    // second stage: multiply rounding and saturation
    always_comb begin
        mul_round = (t_wide'(r1_prod) + MUL_HALF) >> FRAC_BITS;
        mul_fin   = finish_mag(r1_neg, mul_round);
        n2        = r1;
        if (r1_is_mul) begin
            n2.res    = mul_fin.res;
            n2.status = mul_fin.ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r2       <= n2;
        r_dly[0] <= r2;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
        r_out <= n_out;
    end

    always_comb begin
        n_out = r_dly[DLY-1];
        if (r_dly[DLY-1].is_div) begin
            n_out.res    = div_res;
            n_out.status = div_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_dly_vld <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r1_valid  <= i_valid;
            r2_valid  <= r1_valid;
            r_dly_vld <= {r_dly_vld[DLY-2:0], r2_valid};
            r_strobe  <= r_dly_vld[DLY-1];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out.res;
    assign o_flag   = r_out.flag;
    assign o_status = r_out.status;

`ifndef NO_ASSERTIONS
    a_flag_only_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_flag |-> o_result == '0 && o_status == ST_OK)
        else $error("compare item carries a non-zero result or status");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_OVF |-> o_result == WORD_MAX || o_result == WORD_MIN)
        else $error("overflow status without a saturated result");

    a_div0_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_DIV0 |-> o_result == WORD_MAX || o_result == WORD_MIN)
        else $error("division by zero status without a saturated result");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_valid, DIV_LAT + 1))
        else $error("result strobe without a matching item taken from the queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("result strobe straight after reset");
`endif

endmodule

### rtl/fixed_point_q24_8_alu_top.sv
// Signed Q24.8 fixed-point alu (add, sub, mul, div, compares, inc, dec, min, max,
// int conversions) with saturation; each accepted item gives exactly one result,
// in order, on o_strobe for a single cycle, which the receiver must take then.
// The latency from the accepting edge to the edge that takes the result is the
// same for every opcode; it is set by the divider pipeline, which works out one
// quotient bit per stage, and all other operations wait in a matching delay line.
// A new item is taken every cycle: the execution side never stalls, so busy only
// rises if the queue between front end and execution side fills, and stays low
// after reset.
// Depends on fxalu_pkg, fxalu_front, fxalu_queue, fxalu_back, fxalu_div.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_top import fxalu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int Q_DEPTH   = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_kind,
    input  t_word      i_operand_a,
    input  t_word      i_operand_b,
    output logic       o_strobe,
    output t_word      o_result,
    output logic       o_flag,
    output logic [1:0] o_status
);

    logic push, full, head_valid;
    t_op  front_op, head_op;

    fxalu_front u_front (
        .i_start     (start),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_full      (full),
        .o_busy      (busy),
        .o_push      (push),
        .o_op        (front_op)
    );

    fxalu_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_op)
    );

    fxalu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_op     (head_op),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_flag   (o_flag),
        .o_status (o_status)
    );

endmodule
